@@ rtl/spa_pkg.sv @@
// ----------------------------------------------------------------------------
// spa_pkg
// shared types and constants of the slot pool allocator
// ----------------------------------------------------------------------------
package spa_pkg;

   localparam int POOL_SLOTS = 1024;
   localparam int SLOT_W     = $clog2(POOL_SLOTS);
   localparam int COUNT_W    = $clog2(POOL_SLOTS + 1);

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      ST_ALLOC   = 2'd0,
      ST_EXHAUST = 2'd1,
      ST_FREED   = 2'd2,
      ST_IGNORED = 2'd3
   } status_type;

   // push port of the free stack
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      logic [SLOT_W-1:0] data;
   } stack_wr_type;

   // lookahead read port of the free stack
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
   } stack_rd_type;

endpackage

@@ rtl/spa_free_stack.sv @@
// ----------------------------------------------------------------------------
// spa_free_stack
// storage of the free stack with one push port and a registered read port
// ----------------------------------------------------------------------------
module spa_free_stack (
   input  logic                       clock,
   input  spa_pkg::stack_wr_type      wr,
   input  spa_pkg::stack_rd_type      rd,
   output logic [spa_pkg::SLOT_W-1:0] rd_data
);

   logic [spa_pkg::SLOT_W-1:0] mem [spa_pkg::POOL_SLOTS];
   logic [spa_pkg::SLOT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         // push and read of the same entry in one cycle: forward the new value
         if (wr.en && (wr.addr == rd.addr)) begin
            rd_data_ff <= wr.data;
         end else begin
            rd_data_ff <= mem[rd.addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/slot_pool_allocator.sv @@
// ----------------------------------------------------------------------------
// slot_pool_allocator
// hands out slot numbers from a bump pointer, then from a lifo free stack
// ----------------------------------------------------------------------------
// path: req beat to rsp beat through the input register and the result register
// throughput: one request per cycle unless rsp_tready stalls the output, set by
//   the single-pass counter update and one-port push / lookahead read of the free stack
// reset: synchronous, clears counters and valids; stack memory is not cleared,
//   an entry is used only after it has been pushed
// ----------------------------------------------------------------------------
module slot_pool_allocator (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [9:0] slot_in, [15:10] zero
   input  logic        req_tuser,   // [0] command

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [9:0] slot_out, [20:10] live_slots, [23:21] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int SW = spa_pkg::SLOT_W;
   localparam int CW = spa_pkg::COUNT_W;
   localparam logic [CW-1:0] POOL = CW'(spa_pkg::POOL_SLOTS);

   // input register
   logic                     s1_valid_ff, s1_valid_in;
   spa_pkg::command_type     s1_cmd_ff;
   logic [SW-1:0]            s1_slot_ff;

   // allocator state
   logic [CW-1:0]            bump_ff, bump_in;
   logic [CW-1:0]            fill_ff, fill_in;
   logic [CW-1:0]            live_ff, live_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   spa_pkg::status_type      rsp_status_ff, status;
   logic [SW-1:0]            rsp_slot_ff, granted;
   logic [CW-1:0]            rsp_live_ff;

   logic                     req_accept;
   logic                     advance;
   logic [CW-1:0]            fill_m1;
   logic [SW-1:0]            top_data;
   spa_pkg::stack_wr_type    stack_wr;
   spa_pkg::stack_rd_type    stack_rd;

   // item moves from input register to result register when the result
   // register is empty or being drained
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   // single-pass update of counters for the item in the input register
   always_comb begin
      bump_in      = bump_ff;
      fill_in      = fill_ff;
      live_in      = live_ff;
      status       = spa_pkg::ST_IGNORED;
      granted      = '0;
      stack_wr     = '0;
      stack_wr.addr = fill_ff[SW-1:0];
      stack_wr.data = s1_slot_ff;

      if (s1_cmd_ff == spa_pkg::CMD_ALLOC) begin
         if (bump_ff < POOL) begin
            // never-used slot from the bump pointer
            granted = bump_ff[SW-1:0];
            bump_in = bump_ff + 1'b1;
            live_in = live_ff + 1'b1;
            status  = spa_pkg::ST_ALLOC;
         end else if (fill_ff == '0) begin
            status  = spa_pkg::ST_EXHAUST;
         end else begin
            // pop: top entry was prefetched when this item was accepted
            fill_in = fill_ff - 1'b1;
            granted = top_data;
            live_in = live_ff + 1'b1;
            status  = spa_pkg::ST_ALLOC;
         end
      end else begin
         if ((live_ff == '0) || ({1'b0, s1_slot_ff} >= POOL) || (fill_ff >= POOL)) begin
            status = spa_pkg::ST_IGNORED;
         end else begin
            stack_wr.en = advance;
            fill_in     = fill_ff + 1'b1;
            live_in     = live_ff - 1'b1;
            status      = spa_pkg::ST_FREED;
            // last live slot returned: pool starts over
            if (live_ff == CW'(1)) begin
               bump_in = '0;
               fill_in = '0;
            end
         end
      end

      if (!advance) begin
         bump_in = bump_ff;
         fill_in = fill_ff;
         live_in = live_ff;
      end
   end

   // prefetch the top of the stack as left by the item now committing
   assign fill_m1       = fill_in - 1'b1;
   assign stack_rd.en   = req_accept;
   assign stack_rd.addr = fill_m1[SW-1:0];

   spa_free_stack u_stack (
      .clock   (clock),
      .wr      (stack_wr),
      .rd      (stack_rd),
      .rd_data (top_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bump_ff      <= '0;
         fill_ff      <= '0;
         live_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         bump_ff      <= bump_in;
         fill_ff      <= fill_in;
         live_ff      <= live_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff  <= spa_pkg::command_type'(req_tuser);
         s1_slot_ff <= req_tdata[SW-1:0];
      end
      if (advance) begin
         rsp_status_ff <= status;
         rsp_slot_ff   <= granted;
         rsp_live_ff   <= live_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_live_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule
